### rtl/core/sha256_pkg.sv
// Shared types, state codes and constant tables of the SHA-256 hash engine.
package sha256_pkg;

    typedef logic [31:0] t_word;

    // Eight 32-bit words; element 0 is h0 (or working variable a).
    typedef logic [7:0][31:0] t_hash;

    // Message schedule taps that one round reads from the sliding window.
    typedef struct packed {
        t_word w0;
        t_word w1;
        t_word w9;
        t_word w14;
    } t_taps;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [5:0] LAST_OFFSET = 6'd63;
    localparam logic [5:0] LEN_OFFSET  = 6'd56;
    localparam logic [2:0] LAST_WORD   = 3'd7;
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    // Initial chaining value.
    function automatic t_word init_hash(input logic [2:0] idx);
        t_word r;
        case (idx)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            3'd7:    r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Round constants.
    function automatic t_word round_k(input logic [5:0] idx);
        t_word r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/sha256_round.sv
// One SHA-256 compression round together with one message schedule step.
module sha256_round (
    input  sha256_pkg::t_hash  i_vars,
    input  sha256_pkg::t_word  i_k,
    input  sha256_pkg::t_taps  i_taps,
    output sha256_pkg::t_hash  o_vars,
    output sha256_pkg::t_word  o_w_next
);
    import sha256_pkg::*;

    function automatic t_word ror(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    t_word big0;
    t_word big1;
    t_word choose;
    t_word major;
    t_word t1;
    t_word t2;
    t_word sg0;
    t_word sg1;

    // Round function on the working variables a..h.
    always_comb begin
        big1   = ror(i_vars[4], 6) ^ ror(i_vars[4], 11) ^ ror(i_vars[4], 25);
        choose = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
        t1     = i_vars[7] + big1 + choose + i_k + i_taps.w0;
        big0   = ror(i_vars[0], 2) ^ ror(i_vars[0], 13) ^ ror(i_vars[0], 22);
        major  = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^
                 (i_vars[1] & i_vars[2]);
        t2     = big0 + major;
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;
    end

    // Next schedule word, sixteen positions ahead of the current one.
    always_comb begin
        sg0      = ror(i_taps.w1, 7) ^ ror(i_taps.w1, 18) ^ (i_taps.w1 >> 3);
        sg1      = ror(i_taps.w14, 17) ^ ror(i_taps.w14, 19) ^ (i_taps.w14 >> 10);
        o_w_next = i_taps.w0 + sg0 + i_taps.w9 + sg1;
    end

endmodule

### rtl/core/sha256_hash_engine_core.sv
// Top level of the streaming SHA-256 hash engine: byte intake, padding, sequencer, output.
// Intake: a byte is taken while idle; the byte that fills a 64-byte block starts a
// compression of 64 rounds and a chaining update, done by the single shared round
// unit. Finalizing pads one byte per cycle (up to two blocks and two compressions),
// then gives the eight digest words, one per cycle when not stalled. No byte is
// taken while a block is compressed or padded. Synchronous active-low reset loads the
// initial hash and clears the counters; the engine returns to that state after each digest.
module sha256_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input bytes.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] byte_valid
    input  logic        i_s_axis_tlast,   // end_of_message
    // Digest words.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    t_state        r_state;
    t_state        n_state;
    t_hash         r_chain;
    t_hash         r_vars;
    t_word         r_win [16];
    logic [5:0]    r_round;
    logic [5:0]    r_fill;
    logic [60:0]   r_count;
    logic [2:0]    r_oidx;
    logic          r_pend;
    logic          r_first;
    logic          r_len;

    logic          wr_en;
    logic [7:0]    wr_byte;
    logic          cnt_inc;
    logic          in_acc;
    logic          out_acc;
    logic [63:0]   bit_len;
    logic [7:0]    len_byte;
    t_taps         taps;
    t_hash         vars_next;
    t_word         w_next;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Length field bytes, most significant first, picked by the block offset.
    assign bit_len  = {r_count, 3'b000};
    assign len_byte = bit_len[{~r_fill[2:0], 3'b000} +: 8];

    // Shared round unit.
    assign taps.w0  = r_win[0];
    assign taps.w1  = r_win[1];
    assign taps.w9  = r_win[9];
    assign taps.w14 = r_win[14];

    sha256_round u_round (
        .i_vars   (r_vars),
        .i_k      (round_k(r_round)),
        .i_taps   (taps),
        .o_vars   (vars_next),
        .o_w_next (w_next)
    );

    // Sequencer: next state and datapath enables.
    always_comb begin
        n_state         = r_state;
        wr_en           = 1'b0;
        wr_byte         = 8'h00;
        cnt_inc         = 1'b0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser) begin
                        wr_en   = 1'b1;
                        wr_byte = i_s_axis_tdata;
                        cnt_inc = 1'b1;
                    end
                    if (i_s_axis_tuser && r_fill == LAST_OFFSET) begin
                        n_state = ST_ROUND;
                    end else if (i_s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (r_len) begin
                    n_state = ST_OUT;
                end else if (r_pend) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (r_first) begin
                    wr_byte = PAD_BYTE;
                end else if (r_len || r_fill == LEN_OFFSET) begin
                    wr_byte = len_byte;
                end else begin
                    wr_byte = 8'h00;
                end
                if (r_fill == LAST_OFFSET) begin
                    n_state = ST_ROUND;
                end
            end
            ST_OUT: begin
                if (i_m_axis_tready && r_oidx == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Counters, padding flags and chaining value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (out_acc && r_oidx == LAST_WORD)) begin
            r_fill  <= '0;
            r_count <= '0;
            r_round <= '0;
            r_oidx  <= '0;
            r_pend  <= 1'b0;
            r_first <= 1'b0;
            r_len   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
        end else begin
            if (wr_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (cnt_inc) begin
                r_count <= r_count + 61'd1;
            end
            if (in_acc && i_s_axis_tlast) begin
                r_pend  <= 1'b1;
                r_first <= 1'b1;
            end
            if (r_state == ST_PAD) begin
                r_first <= 1'b0;
                if (!r_first && r_fill == LEN_OFFSET) begin
                    r_len <= 1'b1;
                end
            end
            if (r_state == ST_ROUND) begin
                r_round <= r_round + 6'd1;
            end else begin
                r_round <= '0;
            end
            if (r_state == ST_UPDATE) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_vars[i];
                end
            end
            if (out_acc) begin
                r_oidx <= r_oidx + 3'd1;
            end
        end
    end

    // Working variables: loaded from the chaining value, then one round per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state != ST_ROUND) begin
            r_vars <= r_chain;
        end else begin
            r_vars <= vars_next;
        end
    end

    // Block buffer doubling as the schedule window: bytes enter big-endian,
    // and each round shifts one word out and the next schedule word in.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_win[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= wr_byte;
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= w_next;
        end
    end

    // Digest words straight from the chaining registers.
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tdata  = r_chain[r_oidx];
    assign o_m_axis_tuser  = r_oidx;
    assign o_m_axis_tlast  = (r_oidx == LAST_WORD);

endmodule
